// File: design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and constants for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int CHR_WINDOWS    = 8;
   localparam int PRESCALE_STEPS = 3;
   localparam int STEP_W         = 2;
   localparam int TIMER_W        = 7;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_PINS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_PRG = 8'd1;

   localparam logic [7:0] RESET_UPPER_PRG = 8'd254;

   localparam logic [3:0] PAGE_PRG0   = 4'h8;
   localparam logic [3:0] PAGE_MIRROR = 4'hB;
   localparam logic [3:0] PAGE_PRG1   = 4'hC;
   localparam logic [3:0] PAGE_CHR_LO = 4'hD;
   localparam logic [3:0] PAGE_CHR_HI = 4'hE;
   localparam logic [3:0] PAGE_IRQ    = 4'hF;

   localparam logic [3:0] REG_BANK      = 4'h0;
   localparam logic [3:0] REG_IRQ_LATCH = 4'h0;
   localparam logic [3:0] REG_IRQ_CTRL  = 4'h1;
   localparam logic [3:0] REG_IRQ_ACK   = 4'h2;
   localparam logic [3:0] REG_MIRROR    = 4'h3;

   localparam logic [7:0] COUNT_TOP = 8'hFF;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
   } req_type;

   typedef struct packed {
      logic [7:0] prg_bank_low16k;
      logic [7:0] prg_bank_c000_8k;
      logic [7:0] chr_bank_zero;
      logic [7:0] chr_bank_one;
      logic [7:0] chr_bank_two;
      logic [7:0] chr_bank_three;
      logic [7:0] chr_bank_four;
      logic [7:0] chr_bank_five;
      logic [7:0] chr_bank_six;
      logic [7:0] chr_bank_seven;
      logic [1:0] mirroring_mode;
      logic       irq_pending;
   } rsp_type;

   typedef struct packed {
      logic       swap_pins;
      logic [7:0] upper_prg;
   } cfg_type;

   // scanline prescale lengths: 114, 114, 113
   function automatic logic [TIMER_W-1:0] step_length(input logic [STEP_W-1:0] step);
      logic [TIMER_W-1:0] len;
      begin
         case (step)
            2'd0:    len = 7'd114;
            2'd1:    len = 7'd114;
            default: len = 7'd113;
         endcase
         return len;
      end
   endfunction

endpackage

// File: design/cbm_core.sv
// ----------------------------------------------------------------------------
// cbm_core
// Mapper state, bus write decode and IRQ prescaler/counter. Produces the
// post-item snapshot combinationally for the result stage.
// ----------------------------------------------------------------------------
module cbm_core import cbm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type snapshot
);

   logic [7:0]         prg0_ff, prg0_in;
   logic [7:0]         prg1_ff, prg1_in;
   logic [7:0]         chr_ff [CHR_WINDOWS];
   logic [7:0]         chr_in [CHR_WINDOWS];
   logic [1:0]         mirror_ff, mirror_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [7:0]         count_ff, count_in;
   logic [7:0]         latch_ff, latch_in;
   logic               ctrl_cycle_ff, ctrl_cycle_in;
   logic               ctrl_rearm_ff, ctrl_rearm_in;
   logic               enabled_ff, enabled_in;
   logic               flag_ff, flag_in;

   logic [15:0]         addr;
   logic [3:0]          page;
   logic [3:0]          sub;
   logic [TIMER_W-1:0]  timer_dec;
   logic [STEP_W-1:0]   step_cur;

   always_comb begin
      prg0_in       = prg0_ff;
      prg1_in       = prg1_ff;
      chr_in        = chr_ff;
      mirror_in     = mirror_ff;
      timer_in      = timer_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      latch_in      = latch_ff;
      ctrl_cycle_in = ctrl_cycle_ff;
      ctrl_rearm_in = ctrl_rearm_ff;
      enabled_in    = enabled_ff;
      flag_in       = flag_ff;

      addr = cfg.swap_pins ?
             {item.bus_address[15:2], item.bus_address[0], item.bus_address[1]} :
             item.bus_address;
      page = addr[15:12];
      sub  = addr[3:0];
      timer_dec = timer_ff - 7'd1;
      step_cur  = (step_ff >= STEP_W'(PRESCALE_STEPS)) ? '0 : step_ff;

      case (item.opcode)
         OP_WRITE: begin
            case (page)
               PAGE_PRG0: begin
                  if (sub == REG_BANK) prg0_in = item.bus_data;
               end
               PAGE_MIRROR: begin
                  if (sub == REG_MIRROR) mirror_in = item.bus_data[3:2];
               end
               PAGE_PRG1: begin
                  if (sub == REG_BANK) prg1_in = item.bus_data;
               end
               PAGE_CHR_LO: begin
                  if (sub[3:2] == 2'b00) chr_in[{1'b0, sub[1:0]}] = item.bus_data;
               end
               PAGE_CHR_HI: begin
                  if (sub[3:2] == 2'b00) chr_in[{1'b1, sub[1:0]}] = item.bus_data;
               end
               PAGE_IRQ: begin
                  case (sub)
                     REG_IRQ_LATCH: latch_in = item.bus_data;
                     REG_IRQ_CTRL: begin
                        ctrl_cycle_in = item.bus_data[2];
                        ctrl_rearm_in = item.bus_data[0];
                        enabled_in    = item.bus_data[1];
                        if (item.bus_data[1]) begin
                           count_in = latch_ff;
                           timer_in = '0;
                           step_in  = '0;
                        end
                        flag_in = 1'b0;
                     end
                     REG_IRQ_ACK: begin
                        enabled_in = ctrl_rearm_ff;
                        flag_in    = 1'b0;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         OP_TICK: begin
            if (enabled_ff) begin
               if (timer_ff != '0 && timer_dec != '0) begin
                  timer_in = timer_dec;
               end else begin
                  if (ctrl_cycle_ff) begin
                     timer_in = 7'd1;
                  end else begin
                     timer_in = step_length(step_cur);
                     step_in  = (step_cur == STEP_W'(PRESCALE_STEPS - 1)) ?
                                '0 : step_cur + 2'd1;
                  end
                  if (count_ff == COUNT_TOP) begin
                     count_in = latch_ff;
                     flag_in  = 1'b1;
                  end else begin
                     count_in = count_ff + 8'd1;
                  end
               end
            end
         end
         OP_RESET: begin
            prg0_in       = '0;
            prg1_in       = cfg.upper_prg;
            timer_in      = '0;
            step_in       = '0;
            count_in      = '0;
            latch_in      = '0;
            ctrl_cycle_in = 1'b0;
            ctrl_rearm_in = 1'b0;
            enabled_in    = 1'b0;
            flag_in       = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg0_ff       <= '0;
         prg1_ff       <= RESET_UPPER_PRG;
         for (int i = 0; i < CHR_WINDOWS; i++) chr_ff[i] <= '0;
         mirror_ff     <= '0;
         timer_ff      <= '0;
         step_ff       <= '0;
         count_ff      <= '0;
         latch_ff      <= '0;
         ctrl_cycle_ff <= 1'b0;
         ctrl_rearm_ff <= 1'b0;
         enabled_ff    <= 1'b0;
         flag_ff       <= 1'b0;
      end else if (accept) begin
         prg0_ff       <= prg0_in;
         prg1_ff       <= prg1_in;
         chr_ff        <= chr_in;
         mirror_ff     <= mirror_in;
         timer_ff      <= timer_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         latch_ff      <= latch_in;
         ctrl_cycle_ff <= ctrl_cycle_in;
         ctrl_rearm_ff <= ctrl_rearm_in;
         enabled_ff    <= enabled_in;
         flag_ff       <= flag_in;
      end
   end

   assign snapshot.prg_bank_low16k  = prg0_in;
   assign snapshot.prg_bank_c000_8k = prg1_in;
   assign snapshot.chr_bank_zero    = chr_in[0];
   assign snapshot.chr_bank_one     = chr_in[1];
   assign snapshot.chr_bank_two     = chr_in[2];
   assign snapshot.chr_bank_three   = chr_in[3];
   assign snapshot.chr_bank_four    = chr_in[4];
   assign snapshot.chr_bank_five    = chr_in[5];
   assign snapshot.chr_bank_six     = chr_in[6];
   assign snapshot.chr_bank_seven   = chr_in[7];
   assign snapshot.mirroring_mode   = mirror_in;
   assign snapshot.irq_pending      = flag_in;

endmodule

// File: design/cartridge_bank_mapper_with_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// Bank mapper with PRG/CHR bank registers and a cycle/scanline IRQ counter.
// Each snapshot is registered in the output register, or in the skid entry.
// Throughput: 1 item per cycle while the skid entry is empty; the two-entry
// output stage lets a new item transfer while rsp_stall holds a response.
// Reset: synchronous; state returns to power-on values followed by a
// mapper reset (C000 bank = 254, swap pins off).
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq import cbm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cfg_type cfg_ff;
   rsp_type snapshot;
   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;
   logic    accept, pop;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign pop       = out_valid_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_pins <= 1'b0;
         cfg_ff.upper_prg <= RESET_UPPER_PRG;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SWAP_PINS: cfg_ff.swap_pins <= csr_wdata[0];
            CSR_UPPER_PRG: cfg_ff.upper_prg <= csr_wdata;
            default: ;
         endcase
      end
   end

   cbm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_data),
      .cfg      (cfg_ff),
      .snapshot (snapshot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (accept) begin
         if (!out_valid_ff || pop) out_ff <= snapshot;
         else skid_ff <= snapshot;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cartridge bank mapper: bus writes, IRQ ticks and
// mapper resets go in through a queue-fed driver, every response is checked
// field by field against an in-bench copy of the mapper state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import cbm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         LONG_HOLD = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = '0;

   cartridge_bank_mapper_with_irq dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mapper state mirror
   logic               cfg_swap;
   logic [7:0]         cfg_upper;
   logic [7:0]         m_prg [2];
   logic [7:0]         m_chr [CHR_WINDOWS];
   logic [1:0]         m_mirror;
   logic [TIMER_W-1:0] m_timer;
   logic [STEP_W-1:0]  m_step;
   logic [7:0]         m_count;
   logic [7:0]         m_latch;
   logic [7:0]         m_ctrl;
   logic               m_irq_on;
   logic               m_irq_flag;

   req_type pending_items [$];
   rsp_type rsp_expected [$];
   int      items_queued   = 0;
   int      items_accepted = 0;
   int      mismatches     = 0;
   bit      req_taken      = 1'b0;
   int      tx_gap         = 0;
   int      tx_idle_max    = 0;
   int      rx_wait        = 0;
   int      rx_idle_max    = 0;
   int      hold_left      = 0;
   bit      hold_request   = 1'b0;

   function automatic void mapper_reset_state();
      m_prg[0]   = 8'h00;
      m_prg[1]   = cfg_upper;
      m_timer    = '0;
      m_step     = '0;
      m_count    = 8'h00;
      m_latch    = 8'h00;
      m_ctrl     = 8'h00;
      m_irq_on   = 1'b0;
      m_irq_flag = 1'b0;
   endfunction

   function automatic rsp_type advance_mapper(input req_type item);
      rsp_type     snap;
      logic [15:0] a;
      logic [7:0]  d;
      bit          clock_counter;
      a = item.bus_address;
      d = item.bus_data;
      case (item.opcode)
         OP_WRITE: begin
            if (cfg_swap) a = {a[15:2], a[0], a[1]};
            case (a[15:12])
               PAGE_PRG0:   if (a[3:0] == REG_BANK) m_prg[0] = d;
               PAGE_MIRROR: if (a[3:0] == REG_MIRROR) m_mirror = d[3:2];
               PAGE_PRG1:   if (a[3:0] == REG_BANK) m_prg[1] = d;
               PAGE_CHR_LO: if (a[3:2] == 2'b00) m_chr[{1'b0, a[1:0]}] = d;
               PAGE_CHR_HI: if (a[3:2] == 2'b00) m_chr[{1'b1, a[1:0]}] = d;
               PAGE_IRQ: begin
                  if (a[3:0] == REG_IRQ_LATCH) begin
                     m_latch = d;
                  end else if (a[3:0] == REG_IRQ_CTRL) begin
                     m_ctrl   = d;
                     m_irq_on = d[1];
                     if (d[1]) begin
                        m_count = m_latch;
                        m_timer = '0;
                        m_step  = '0;
                     end
                     m_irq_flag = 1'b0;
                  end else if (a[3:0] == REG_IRQ_ACK) begin
                     m_irq_on   = m_ctrl[0];
                     m_irq_flag = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         OP_TICK: begin
            if (m_irq_on) begin
               clock_counter = 1'b1;
               if (m_timer != '0) begin
                  m_timer = m_timer - 1'b1;
                  if (m_timer != '0) clock_counter = 1'b0;
               end
               if (clock_counter) begin
                  if (m_ctrl[2]) begin
                     m_timer = m_timer + 1'b1;
                  end else begin
                     if (m_step >= PRESCALE_STEPS) m_step = '0;
                     m_timer = m_timer +
                        ((m_step == STEP_W'(PRESCALE_STEPS - 1)) ? 7'd113 : 7'd114);
                     m_step = m_step + 1'b1;
                     if (m_step >= PRESCALE_STEPS) m_step = '0;
                  end
                  if (m_count == COUNT_TOP) begin
                     m_count    = m_latch;
                     m_irq_flag = 1'b1;
                  end else begin
                     m_count = m_count + 1'b1;
                  end
               end
            end
         end
         OP_RESET: mapper_reset_state();
         default: ;
      endcase
      snap.prg_bank_low16k  = m_prg[0];
      snap.prg_bank_c000_8k = m_prg[1];
      snap.chr_bank_zero    = m_chr[0];
      snap.chr_bank_one     = m_chr[1];
      snap.chr_bank_two     = m_chr[2];
      snap.chr_bank_three   = m_chr[3];
      snap.chr_bank_four    = m_chr[4];
      snap.chr_bank_five    = m_chr[5];
      snap.chr_bank_six     = m_chr[6];
      snap.chr_bank_seven   = m_chr[7];
      snap.mirroring_mode   = m_mirror;
      snap.irq_pending      = m_irq_flag;
      return snap;
   endfunction

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %02h actual %02h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // driver: request side, changes at the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
            tx_gap = $urandom_range(0, tx_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, long hold-off counted here
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         rsp_expected.push_back(advance_mapper(req_data));
         items_accepted++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: response transfer with nothing expected, actual %h",
                     $time, rsp_data);
            mismatches++;
         end else begin
            want = rsp_expected.pop_front();
            check_field("prg_bank_low16k", want.prg_bank_low16k, rsp_data.prg_bank_low16k);
            check_field("prg_bank_c000_8k", want.prg_bank_c000_8k,
                        rsp_data.prg_bank_c000_8k);
            check_field("chr_bank_zero", want.chr_bank_zero, rsp_data.chr_bank_zero);
            check_field("chr_bank_one", want.chr_bank_one, rsp_data.chr_bank_one);
            check_field("chr_bank_two", want.chr_bank_two, rsp_data.chr_bank_two);
            check_field("chr_bank_three", want.chr_bank_three, rsp_data.chr_bank_three);
            check_field("chr_bank_four", want.chr_bank_four, rsp_data.chr_bank_four);
            check_field("chr_bank_five", want.chr_bank_five, rsp_data.chr_bank_five);
            check_field("chr_bank_six", want.chr_bank_six, rsp_data.chr_bank_six);
            check_field("chr_bank_seven", want.chr_bank_seven, rsp_data.chr_bank_seven);
            check_field("mirroring_mode", 8'(want.mirroring_mode),
                        8'(rsp_data.mirroring_mode));
            check_field("irq_pending", 8'(want.irq_pending), 8'(rsp_data.irq_pending));
         end
         rx_wait = $urandom_range(0, rx_idle_max);
      end
   end

   task automatic queue_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
      req_type item;
      item.opcode      = op;
      item.bus_address = addr;
      item.bus_data    = data;
      pending_items.push_back(item);
      items_queued++;
   endtask

   // address that hits a register once the pin swap in force is undone
   function automatic logic [15:0] decoded_address(input logic [3:0] page,
                                                   input logic [3:0] sel);
      logic [15:0] a;
      a = {page, 8'($urandom), sel};
      if (cfg_swap) a = {a[15:2], a[0], a[1]};
      return a;
   endfunction

   task automatic queue_bank_write();
      logic [3:0] page;
      logic [3:0] sel;
      case ($urandom_range(0, 4))
         0: begin page = PAGE_PRG0;   sel = REG_BANK;   end
         1: begin page = PAGE_MIRROR; sel = REG_MIRROR; end
         2: begin page = PAGE_PRG1;   sel = REG_BANK;   end
         3: begin page = PAGE_CHR_LO; sel = 4'($urandom_range(0, 3)); end
         default: begin page = PAGE_CHR_HI; sel = 4'($urandom_range(0, 3)); end
      endcase
      queue_item(OP_WRITE, decoded_address(page, sel), 8'($urandom));
   endtask

   task automatic queue_random_mix(input int count);
      int         added;
      int         kind;
      int         burst;
      logic [7:0] value;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            queue_bank_write();
            added++;
         end else if (kind < 55) begin
            case ($urandom_range(0, 2))
               0: begin
                  value = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hFF))
                                               : 8'($urandom);
                  queue_item(OP_WRITE, decoded_address(PAGE_IRQ, REG_IRQ_LATCH), value);
               end
               1: begin
                  value = 8'($urandom);
                  if ($urandom_range(0, 3) != 0) value[1] = 1'b1;
                  queue_item(OP_WRITE, decoded_address(PAGE_IRQ, REG_IRQ_CTRL), value);
               end
               default:
                  queue_item(OP_WRITE, decoded_address(PAGE_IRQ, REG_IRQ_ACK),
                             8'($urandom));
            endcase
            added++;
         end else if (kind < 85) begin
            burst = $urandom_range(1, 8);
            repeat (burst) queue_item(OP_TICK, 16'($urandom), 8'($urandom));
            added += burst;
         end else if (kind < 90) begin
            queue_item(OP_RESET, 16'($urandom), 8'($urandom));
            added++;
         end else if (kind < 95) begin
            queue_item(OP_UNUSED, 16'($urandom), 8'($urandom));
         end else begin
            queue_item(OP_WRITE, 16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SWAP_PINS: cfg_swap  = data[0];
         CSR_UPPER_PRG: cfg_upper = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic start_phase(input int tx_max, input int rx_max);
      @(posedge clock);
      tx_idle_max = tx_max;
      rx_idle_max = rx_max;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || rsp_expected.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [7:0] value;
      cfg_swap  = 1'b0;
      cfg_upper = RESET_UPPER_PRG;
      m_prg[0]  = 8'h00;
      m_prg[1]  = 8'h00;
      for (int i = 0; i < CHR_WINDOWS; i++) m_chr[i] = 8'h00;
      m_mirror = 2'd0;
      mapper_reset_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: bank extremes, decode holes, unknown opcode, IRQ overflow
      start_phase(4, 4);
      queue_item(OP_WRITE, 16'h8000, 8'hFF);
      queue_item(OP_WRITE, 16'hC000, 8'h00);
      queue_item(OP_WRITE, 16'hD000, 8'hFF);
      queue_item(OP_WRITE, 16'hD001, 8'h00);
      queue_item(OP_WRITE, 16'hD002, 8'hA5);
      queue_item(OP_WRITE, 16'hD003, 8'h5A);
      queue_item(OP_WRITE, 16'hE000, 8'h01);
      queue_item(OP_WRITE, 16'hE001, 8'h80);
      queue_item(OP_WRITE, 16'hE002, 8'h7F);
      queue_item(OP_WRITE, 16'hE003, 8'hFE);
      queue_item(OP_WRITE, 16'hB003, 8'h0C);
      queue_item(OP_WRITE, 16'hB003, 8'h04);
      queue_item(OP_WRITE, 16'hFFFF, 8'hFF);
      queue_item(OP_WRITE, 16'h0000, 8'h00);
      queue_item(OP_WRITE, 16'h8001, 8'h55);
      queue_item(OP_UNUSED, 16'h8000, 8'h77);
      queue_item(OP_TICK, 16'h0000, 8'h00);
      queue_item(OP_WRITE, 16'hF000, 8'hFE);
      queue_item(OP_WRITE, 16'hF001, 8'h06);
      repeat (3) queue_item(OP_TICK, 16'hFFFF, 8'hFF);
      queue_item(OP_WRITE, 16'hF002, 8'h00);
      queue_item(OP_TICK, 16'h0000, 8'h00);
      queue_item(OP_RESET, 16'h0000, 8'h00);
      wait_drained();

      // swapped pins, lowest upper bank, no idling, long receiver hold
      value = 8'($urandom);
      write_csr(CSR_SWAP_PINS, value | 8'h01);
      write_csr(CSR_UPPER_PRG, 8'h00);
      write_csr(CSR_IDX_W'($urandom_range(2, 255)), 8'($urandom));
      start_phase(0, 0);
      queue_random_mix(30);
      hold_request = 1'b1;
      wait_drained();

      // scanline prescaler run through all three steps, with acks and bank writes
      value = 8'($urandom);
      write_csr(CSR_SWAP_PINS, value & 8'hFE);
      write_csr(CSR_UPPER_PRG, 8'hFF);
      start_phase(4, 4);
      queue_item(OP_WRITE, decoded_address(PAGE_IRQ, REG_IRQ_LATCH),
                 8'($urandom_range(8'hFE, 8'hFF)));
      value = (8'($urandom) & 8'hFB) | 8'h03;
      queue_item(OP_WRITE, decoded_address(PAGE_IRQ, REG_IRQ_CTRL), value);
      repeat (370) begin
         case ($urandom_range(0, 39))
            0: queue_item(OP_WRITE, decoded_address(PAGE_IRQ, REG_IRQ_ACK), 8'($urandom));
            1: queue_bank_write();
            default: queue_item(OP_TICK, 16'($urandom), 8'($urandom));
         endcase
      end
      wait_drained();

      // swapped pins again, random upper bank, idling and a second hold
      value = 8'($urandom);
      write_csr(CSR_SWAP_PINS, value | 8'h01);
      write_csr(CSR_UPPER_PRG, 8'($urandom));
      start_phase(4, 4);
      queue_random_mix(30);
      hold_request = 1'b1;
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
design/cbm_pkg.sv
design/cbm_core.sv
design/cartridge_bank_mapper_with_irq.sv
sim/testbench.sv
